FILE: rtl/ntsc_pkg.sv
// Shared constants and types for the Newick tree syntax checker.
package ntsc_pkg;

	localparam int MAX_DEPTH = 64;
	localparam int LEVEL_W = $clog2(MAX_DEPTH + 1);
	localparam int ADDR_W = $clog2(MAX_DEPTH);
	localparam int DEPTH_W = 7;
	localparam int COUNT_W = 16;
	localparam int STEPS = 6;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_NONE = 8'h00;

	localparam logic [1:0] ST_RUNNING = 2'd0;
	localparam logic [1:0] ST_ACCEPTED = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_WRONG_CHAR = 2'd1;
	localparam logic [1:0] ERR_NONZERO_DIGIT = 2'd2;
	localparam logic [1:0] ERR_TOO_DEEP = 2'd3;

	localparam logic [3:0] P_TREE = 4'd0;
	localparam logic [3:0] P_NAME = 4'd1;
	localparam logic [3:0] P_SEP1 = 4'd2;
	localparam logic [3:0] P_COLON = 4'd3;
	localparam logic [3:0] P_SEP2 = 4'd4;
	localparam logic [3:0] P_INT = 4'd5;
	localparam logic [3:0] P_INT_MORE = 4'd6;
	localparam logic [3:0] P_AFTER_INT = 4'd7;
	localparam logic [3:0] P_FRAC = 4'd8;
	localparam logic [3:0] P_NUM_END = 4'd9;
	localparam logic [3:0] P_SEP3 = 4'd10;

	typedef struct packed {
		logic letter;
		logic digit;
		logic sep;
		logic lparen;
		logic rparen;
		logic colon;
		logic comma;
		logic under;
		logic dot;
		logic zero;
	} cls_t;

	typedef struct packed {
		logic [3:0] pos;
		logic take;
		logic fail;
		logic [1:0] kind;
		logic [7:0] expect_ch;
		logic accept;
		logic push;
		logic pop;
		logic set_top;
	} step_t;

endpackage

FILE: rtl/newick_tree_syntax_checker_core.sv
// Top level of the Newick tree syntax checker: one character per request.
//
// The request channel (req_valid, req_stall) carries one character, a first
// flag that restarts the parser, and an end_of_text flag for a character that
// matches nothing. Every accepted request gives exactly one result on the
// result channel (res_valid, res_stall): status, error kind, expected
// character, characters consumed so far and the open nesting depth.
// The result appears in the cycle after the request is accepted, and a new request
// can be accepted in every cycle while req_stall is low, so throughput is one
// character per cycle; the grammar position lookahead chain is combinational.
// The open-child bit of every level but the innermost lives in a small RAM
// whose read is prefetched for the level below the current one.
// When the receiver stalls a pending result, the result stays unchanged and
// req_stall is raised until that result is taken.
// Reset leaves no result pending and puts the parser at the start of a tree.
// Once a tree is accepted or an error is found, the result is held until a
// request with first set.
module newick_tree_syntax_checker_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [7:0] ch,
	input  logic       first,
	input  logic       end_of_text,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] status,
	output logic [1:0] error_kind,
	output logic [7:0] expected_char,
	output logic [15:0] position,
	output logic [6:0] depth
);

	logic [3:0] pos_q;
	logic [ntsc_pkg::LEVEL_W-1:0] lv_q;
	logic top_q;
	logic [1:0] verdict_q;
	logic [1:0] kind_q;
	logic [7:0] exp_q;
	logic [ntsc_pkg::COUNT_W-1:0] cnt_q;
	logic res_valid_q;

	logic accept_req;
	ntsc_pkg::cls_t cls;
	logic have;

	logic [3:0] e_pos;
	logic [ntsc_pkg::LEVEL_W-1:0] e_lv;
	logic e_top;
	logic [1:0] e_verdict;
	logic [1:0] e_kind;
	logic [7:0] e_exp;
	logic [ntsc_pkg::COUNT_W-1:0] e_cnt;

	logic [3:0] n_pos;
	logic [ntsc_pkg::LEVEL_W-1:0] n_lv;
	logic n_top;
	logic [1:0] n_verdict;
	logic [1:0] n_kind;
	logic [7:0] n_exp;
	logic [ntsc_pkg::COUNT_W-1:0] n_cnt;

	ntsc_pkg::step_t evt;
	ntsc_pkg::step_t stp;
	logic halt;
	logic [3:0] walk_pos;

	logic ram_we;
	logic [ntsc_pkg::ADDR_W-1:0] ram_waddr;
	logic [ntsc_pkg::ADDR_W-1:0] ram_raddr;
	logic ram_rdata;

	function automatic ntsc_pkg::step_t step_fn(
		input logic [3:0] pos,
		input ntsc_pkg::cls_t c,
		input logic top,
		input logic [ntsc_pkg::LEVEL_W-1:0] lv
	);
		ntsc_pkg::step_t r;
		r = '0;
		r.pos = pos;
		unique case (pos)
			ntsc_pkg::P_TREE: begin
				if (c.lparen) begin
					if (lv >= ntsc_pkg::LEVEL_W'(ntsc_pkg::MAX_DEPTH)) begin
						r.fail = 1'b1;
						r.kind = ntsc_pkg::ERR_TOO_DEEP;
					end else begin
						r.push = 1'b1;
						r.take = 1'b1;
					end
				end else begin
					r.pos = ntsc_pkg::P_NAME;
				end
			end
			ntsc_pkg::P_NAME: begin
				if (c.letter || c.under) begin
					r.take = 1'b1;
				end else if (lv == '0) begin
					r.accept = 1'b1;
				end else begin
					r.pos = ntsc_pkg::P_SEP1;
				end
			end
			ntsc_pkg::P_SEP1: begin
				if (c.sep) r.take = 1'b1;
				else r.pos = ntsc_pkg::P_COLON;
			end
			ntsc_pkg::P_COLON: begin
				if (c.colon) begin
					r.take = 1'b1;
					r.pos = ntsc_pkg::P_SEP2;
				end else begin
					r.fail = 1'b1;
					r.kind = ntsc_pkg::ERR_WRONG_CHAR;
					r.expect_ch = ntsc_pkg::CH_COLON;
				end
			end
			ntsc_pkg::P_SEP2: begin
				if (c.sep) r.take = 1'b1;
				else r.pos = ntsc_pkg::P_INT;
			end
			ntsc_pkg::P_INT: begin
				if (c.zero) begin
					r.take = 1'b1;
					r.pos = ntsc_pkg::P_AFTER_INT;
				end else if (c.digit) begin
					r.take = 1'b1;
					r.pos = ntsc_pkg::P_INT_MORE;
				end else begin
					r.fail = 1'b1;
					r.kind = ntsc_pkg::ERR_NONZERO_DIGIT;
				end
			end
			ntsc_pkg::P_INT_MORE: begin
				if (c.digit) r.take = 1'b1;
				else r.pos = ntsc_pkg::P_AFTER_INT;
			end
			ntsc_pkg::P_AFTER_INT: begin
				if (c.dot) begin
					r.take = 1'b1;
					r.pos = ntsc_pkg::P_FRAC;
				end else begin
					r.pos = ntsc_pkg::P_NUM_END;
				end
			end
			ntsc_pkg::P_FRAC: begin
				if (c.digit) r.take = 1'b1;
				else r.pos = ntsc_pkg::P_NUM_END;
			end
			ntsc_pkg::P_NUM_END: begin
				if (!top) begin
					if (c.comma) begin
						r.set_top = 1'b1;
						r.take = 1'b1;
						r.pos = ntsc_pkg::P_SEP3;
					end else begin
						r.fail = 1'b1;
						r.kind = ntsc_pkg::ERR_WRONG_CHAR;
						r.expect_ch = ntsc_pkg::CH_COMMA;
					end
				end else begin
					if (c.rparen) begin
						r.take = 1'b1;
						r.pop = 1'b1;
						if (lv <= ntsc_pkg::LEVEL_W'(1)) r.accept = 1'b1;
						else r.pos = ntsc_pkg::P_SEP1;
					end else begin
						r.fail = 1'b1;
						r.kind = ntsc_pkg::ERR_WRONG_CHAR;
						r.expect_ch = ntsc_pkg::CH_RPAREN;
					end
				end
			end
			ntsc_pkg::P_SEP3: begin
				if (c.sep) r.take = 1'b1;
				else r.pos = ntsc_pkg::P_TREE;
			end
			default: begin
				r.pos = ntsc_pkg::P_TREE;
			end
		endcase
		return r;
	endfunction

	assign req_stall = res_valid_q && res_stall;
	assign accept_req = req_valid && !req_stall;

	assign have = !end_of_text;
	always_comb begin
		cls.letter = have && ((ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A));
		cls.digit = have && ch >= ntsc_pkg::CH_ZERO && ch <= ntsc_pkg::CH_NINE;
		cls.sep = have && (ch == ntsc_pkg::CH_SPACE || ch == ntsc_pkg::CH_TAB ||
			ch == ntsc_pkg::CH_LF || ch == ntsc_pkg::CH_CR);
		cls.lparen = have && ch == ntsc_pkg::CH_LPAREN;
		cls.rparen = have && ch == ntsc_pkg::CH_RPAREN;
		cls.colon = have && ch == ntsc_pkg::CH_COLON;
		cls.comma = have && ch == ntsc_pkg::CH_COMMA;
		cls.under = have && ch == ntsc_pkg::CH_UNDER;
		cls.dot = have && ch == ntsc_pkg::CH_DOT;
		cls.zero = have && ch == ntsc_pkg::CH_ZERO;
	end

	always_comb begin
		if (first) begin
			e_pos = ntsc_pkg::P_TREE;
			e_lv = '0;
			e_top = 1'b0;
			e_verdict = ntsc_pkg::ST_RUNNING;
			e_kind = ntsc_pkg::ERR_NONE;
			e_exp = ntsc_pkg::CH_NONE;
			e_cnt = '0;
		end else begin
			e_pos = pos_q;
			e_lv = lv_q;
			e_top = top_q;
			e_verdict = verdict_q;
			e_kind = kind_q;
			e_exp = exp_q;
			e_cnt = cnt_q;
		end
	end

	always_comb begin
		evt = '0;
		stp = '0;
		walk_pos = e_pos;
		halt = (e_verdict != ntsc_pkg::ST_RUNNING);
		for (int i = 0; i < ntsc_pkg::STEPS; i++) begin
			if (!halt) begin
				stp = step_fn(walk_pos, cls, e_top, e_lv);
				walk_pos = stp.pos;
				if (stp.take || stp.fail || stp.accept) begin
					evt = stp;
					halt = 1'b1;
				end
			end
		end
	end

	always_comb begin
		n_pos = walk_pos;
		n_verdict = e_verdict;
		n_kind = e_kind;
		n_exp = e_exp;
		if (evt.fail) begin
			n_verdict = ntsc_pkg::ST_ERROR;
			n_kind = evt.kind;
			n_exp = evt.expect_ch;
		end else if (evt.accept) begin
			n_verdict = ntsc_pkg::ST_ACCEPTED;
		end
		if (evt.push) n_lv = e_lv + ntsc_pkg::LEVEL_W'(1);
		else if (evt.pop) n_lv = e_lv - ntsc_pkg::LEVEL_W'(1);
		else n_lv = e_lv;
		if (evt.push) n_top = 1'b0;
		else if (evt.pop) n_top = ram_rdata;
		else if (evt.set_top) n_top = 1'b1;
		else n_top = e_top;
		if (evt.take && e_cnt != {ntsc_pkg::COUNT_W{1'b1}}) begin
			n_cnt = e_cnt + ntsc_pkg::COUNT_W'(1);
		end else begin
			n_cnt = e_cnt;
		end
	end

	assign ram_we = accept_req && evt.push && (e_lv != '0);
	assign ram_waddr = ntsc_pkg::ADDR_W'(e_lv - ntsc_pkg::LEVEL_W'(1));
	assign ram_raddr = ntsc_pkg::ADDR_W'(lv_q - ntsc_pkg::LEVEL_W'(2));

	ntsc_ram #(
		.WIDTH(1),
		.DEPTH(ntsc_pkg::MAX_DEPTH)
	) u_stack (
		.clk(clk),
		.wr_en(ram_we),
		.wr_addr(ram_waddr),
		.wr_data(e_top),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= ntsc_pkg::P_TREE;
			lv_q <= '0;
			top_q <= 1'b0;
			verdict_q <= ntsc_pkg::ST_RUNNING;
			kind_q <= ntsc_pkg::ERR_NONE;
			exp_q <= ntsc_pkg::CH_NONE;
			cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept_req) begin
				pos_q <= n_pos;
				lv_q <= n_lv;
				top_q <= n_top;
				verdict_q <= n_verdict;
				kind_q <= n_kind;
				exp_q <= n_exp;
				cnt_q <= n_cnt;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign status = verdict_q;
	assign error_kind = kind_q;
	assign expected_char = exp_q;
	assign position = cnt_q;
	assign depth = ntsc_pkg::DEPTH_W'(lv_q);

endmodule

FILE: rtl/ntsc_ram.sv
// Generic single-port-write RAM with a registered read port.
module ntsc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: rtl/ntsc_checker.sv
// Port-level assertions for the Newick tree syntax checker, bound to the top level.
module ntsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_stall,
	input logic       first,
	input logic       end_of_text,
	input logic       res_valid,
	input logic       res_stall,
	input logic [1:0] status,
	input logic [1:0] error_kind,
	input logic [7:0] expected_char,
	input logic [15:0] position,
	input logic [6:0] depth
);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> res_valid)
		else $error("Accepted request produced no result.");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(status) && $stable(position))
		else $error("Stalled result changed.");

	a_kind_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((status == ntsc_pkg::ST_ERROR) == (error_kind != ntsc_pkg::ERR_NONE)))
		else $error("Error kind disagrees with status.");

	a_expected_char: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && error_kind != ntsc_pkg::ERR_WRONG_CHAR |-> expected_char == ntsc_pkg::CH_NONE)
		else $error("Expected character set without a wrong-character error.");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && first && end_of_text |=> position == 16'd0 && depth == 7'd0)
		else $error("Restart did not clear position and depth.");

endmodule

bind newick_tree_syntax_checker_core ntsc_checker u_ntsc_checker (.*);

FILE: dv/newick_tree_syntax_checker_core_tb.sv
// Testbench for the Newick tree syntax checker core with a self-checking scoreboard.
module newick_tree_syntax_checker_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] status;
		logic [1:0] kind;
		logic [7:0] want_ch;
		logic [15:0] consumed;
		logic [6:0] levels;
	} parse_report_t;

	class grammar_scoreboard;
		logic [3:0] pos;
		int unsigned levels;
		bit open_child [ntsc_pkg::MAX_DEPTH];
		logic [1:0] verdict;
		logic [1:0] kind;
		logic [7:0] want_ch;
		int unsigned consumed;
		parse_report_t report_q[$];
		int mismatches;
		int checked;
		int accepted_seen;
		int errors_seen;
		int deepest;

		function new();
			restart();
		endfunction

		function void restart();
			pos = ntsc_pkg::P_TREE;
			levels = 0;
			foreach (open_child[i]) open_child[i] = 1'b0;
			verdict = ntsc_pkg::ST_RUNNING;
			consumed = 0;
			kind = ntsc_pkg::ERR_NONE;
			want_ch = ntsc_pkg::CH_NONE;
		endfunction

		function void fail_with(logic [1:0] k, logic [7:0] w);
			verdict = ntsc_pkg::ST_ERROR;
			kind = k;
			want_ch = w;
		endfunction

		function void close_tree();
			if (levels == 0) verdict = ntsc_pkg::ST_ACCEPTED;
			else pos = ntsc_pkg::P_SEP1;
		endfunction

		function int outstanding();
			return report_q.size();
		endfunction

		// Advances the grammar by one request; a character may walk several
		// positions before it is consumed.
		function void note_char(logic [7:0] c, logic f, logic e);
			bit have, letter, digit, blank, took;
			int unsigned top;
			parse_report_t r;
			have = !e;
			if (f) restart();
			letter = have && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"));
			digit = have && c >= ntsc_pkg::CH_ZERO && c <= ntsc_pkg::CH_NINE;
			blank = have && (c == ntsc_pkg::CH_SPACE || c == ntsc_pkg::CH_TAB ||
				c == ntsc_pkg::CH_LF || c == ntsc_pkg::CH_CR);
			for (int guard = 0; guard < 32 && verdict == ntsc_pkg::ST_RUNNING; guard++) begin
				took = 1'b0;
				top = (levels == 0) ? 0 : levels - 1;
				case (pos)
					ntsc_pkg::P_TREE: begin
						if (have && c == ntsc_pkg::CH_LPAREN) begin
							if (levels >= ntsc_pkg::MAX_DEPTH) begin
								fail_with(ntsc_pkg::ERR_TOO_DEEP, ntsc_pkg::CH_NONE);
							end else begin
								open_child[levels] = 1'b0;
								levels++;
								took = 1'b1;
							end
						end else begin
							pos = ntsc_pkg::P_NAME;
						end
					end
					ntsc_pkg::P_NAME: begin
						if (letter || (have && c == ntsc_pkg::CH_UNDER)) took = 1'b1;
						else close_tree();
					end
					ntsc_pkg::P_SEP1: begin
						if (blank) took = 1'b1;
						else pos = ntsc_pkg::P_COLON;
					end
					ntsc_pkg::P_COLON: begin
						if (have && c == ntsc_pkg::CH_COLON) begin
							took = 1'b1;
							pos = ntsc_pkg::P_SEP2;
						end else begin
							fail_with(ntsc_pkg::ERR_WRONG_CHAR, ntsc_pkg::CH_COLON);
						end
					end
					ntsc_pkg::P_SEP2: begin
						if (blank) took = 1'b1;
						else pos = ntsc_pkg::P_INT;
					end
					ntsc_pkg::P_INT: begin
						if (have && c == ntsc_pkg::CH_ZERO) begin
							took = 1'b1;
							pos = ntsc_pkg::P_AFTER_INT;
						end else if (digit) begin
							took = 1'b1;
							pos = ntsc_pkg::P_INT_MORE;
						end else begin
							fail_with(ntsc_pkg::ERR_NONZERO_DIGIT, ntsc_pkg::CH_NONE);
						end
					end
					ntsc_pkg::P_INT_MORE: begin
						if (digit) took = 1'b1;
						else pos = ntsc_pkg::P_AFTER_INT;
					end
					ntsc_pkg::P_AFTER_INT: begin
						if (have && c == ntsc_pkg::CH_DOT) begin
							took = 1'b1;
							pos = ntsc_pkg::P_FRAC;
						end else begin
							pos = ntsc_pkg::P_NUM_END;
						end
					end
					ntsc_pkg::P_FRAC: begin
						if (digit) took = 1'b1;
						else pos = ntsc_pkg::P_NUM_END;
					end
					ntsc_pkg::P_NUM_END: begin
						if (!open_child[top]) begin
							if (have && c == ntsc_pkg::CH_COMMA) begin
								open_child[top] = 1'b1;
								took = 1'b1;
								pos = ntsc_pkg::P_SEP3;
							end else begin
								fail_with(ntsc_pkg::ERR_WRONG_CHAR, ntsc_pkg::CH_COMMA);
							end
						end else if (have && c == ntsc_pkg::CH_RPAREN) begin
							took = 1'b1;
							if (levels != 0) levels--;
							close_tree();
						end else begin
							fail_with(ntsc_pkg::ERR_WRONG_CHAR, ntsc_pkg::CH_RPAREN);
						end
					end
					ntsc_pkg::P_SEP3: begin
						if (blank) took = 1'b1;
						else pos = ntsc_pkg::P_TREE;
					end
					default: pos = ntsc_pkg::P_TREE;
				endcase
				if (took) begin
					if (consumed < 16'hFFFF) consumed++;
					break;
				end
			end
			r.status = verdict;
			r.kind = kind;
			r.want_ch = want_ch;
			r.consumed = consumed[15:0];
			r.levels = levels[6:0];
			report_q.push_back(r);
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				if (mismatches <= 50)
					$error("%s mismatch: expected %0d, got %0d", field, want, got);
			end
		endfunction

		function void check_result(logic [1:0] st, logic [1:0] ek, logic [7:0] xc,
				logic [15:0] p, logic [6:0] d);
			parse_report_t r;
			checked++;
			if (report_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 50) $error("Result arrived with no request pending.");
				return;
			end
			r = report_q.pop_front();
			compare("status", r.status, st);
			compare("error_kind", r.kind, ek);
			compare("expected_char", r.want_ch, xc);
			compare("position", r.consumed, p);
			compare("depth", r.levels, d);
			if (r.status == ntsc_pkg::ST_ACCEPTED) accepted_seen++;
			if (r.status == ntsc_pkg::ST_ERROR) errors_seen++;
			if (r.levels > deepest) deepest = r.levels;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [7:0] ch = 8'h00;
	logic first = 1'b0;
	logic end_of_text = 1'b0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [1:0] status;
	logic [1:0] error_kind;
	logic [7:0] expected_char;
	logic [15:0] position;
	logic [6:0] depth;

	grammar_scoreboard sb = new();
	logic [7:0] tree_text[$];
	bit steady = 1'b0;
	bit long_hold_done = 1'b0;
	int chars_sent = 0;

	newick_tree_syntax_checker_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.ch(ch),
		.first(first),
		.end_of_text(end_of_text),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.error_kind(error_kind),
		.expected_char(expected_char),
		.position(position),
		.depth(depth)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void put_digit(bit nonzero);
		tree_text.push_back(8'(ntsc_pkg::CH_ZERO +
			(nonzero ? $urandom_range(9, 1) : $urandom_range(9))));
	endfunction

	function automatic void put_name();
		repeat ($urandom_range(4)) begin
			case ($urandom_range(2))
				0: tree_text.push_back(ntsc_pkg::CH_UNDER);
				1: tree_text.push_back(8'("a" + $urandom_range(25)));
				default: tree_text.push_back(8'("A" + $urandom_range(25)));
			endcase
		end
	endfunction

	function automatic void put_blanks();
		if ($urandom_range(2) == 0) begin
			repeat ($urandom_range(2, 1)) begin
				case ($urandom_range(3))
					0: tree_text.push_back(ntsc_pkg::CH_SPACE);
					1: tree_text.push_back(ntsc_pkg::CH_TAB);
					2: tree_text.push_back(ntsc_pkg::CH_LF);
					default: tree_text.push_back(ntsc_pkg::CH_CR);
				endcase
			end
		end
	endfunction

	function automatic void put_number();
		if ($urandom_range(3) == 0) begin
			tree_text.push_back(ntsc_pkg::CH_ZERO);
		end else begin
			put_digit(1'b1);
			repeat ($urandom_range(3)) put_digit(1'b0);
		end
		if ($urandom_range(1)) begin
			tree_text.push_back(ntsc_pkg::CH_DOT);
			repeat ($urandom_range(3)) put_digit(1'b0);
		end
	endfunction

	// With spine set, the first child always nests further, so the tree is
	// exactly budget levels deep.
	function automatic void put_tree(int budget, bit spine);
		if (budget == 0 || (!spine && $urandom_range(2) == 0)) begin
			put_name();
		end else begin
			tree_text.push_back(ntsc_pkg::CH_LPAREN);
			put_tree(budget - 1, spine);
			put_blanks();
			tree_text.push_back(ntsc_pkg::CH_COLON);
			put_blanks();
			put_number();
			tree_text.push_back(ntsc_pkg::CH_COMMA);
			put_blanks();
			put_tree(spine ? 0 : budget - 1, 1'b0);
			put_blanks();
			tree_text.push_back(ntsc_pkg::CH_COLON);
			put_blanks();
			put_number();
			tree_text.push_back(ntsc_pkg::CH_RPAREN);
		end
	endfunction

	task automatic send_char(input logic [7:0] c, input logic f, input logic e);
		while (!steady && $urandom_range(99) < 24) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		ch <= c;
		first <= f;
		end_of_text <= e;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_char(c, f, e);
		chars_sent++;
	endtask

	task automatic send_text(input bit add_end);
		if (tree_text.size() == 0) begin
			send_char(8'($urandom_range(255)), 1'b1, 1'b1);
		end else begin
			foreach (tree_text[i]) send_char(tree_text[i], i == 0, 1'b0);
			if (add_end) send_char(8'($urandom_range(255)), 1'b0, 1'b1);
		end
	endtask

	task automatic send_string(input string s, input bit add_end);
		tree_text.delete();
		for (int i = 0; i < s.len(); i++) tree_text.push_back(s[i]);
		send_text(add_end);
	endtask

	// Mostly well-formed trees with random content, some with one character
	// replaced or cut short, and some plain noise.
	task automatic random_sequence();
		int pick;
		int cut;
		tree_text.delete();
		pick = $urandom_range(99);
		if (pick < 10) begin
			repeat ($urandom_range(6, 1)) tree_text.push_back(8'($urandom_range(255)));
		end else begin
			put_tree($urandom_range(4), 1'b0);
			if (pick < 25 && tree_text.size() > 0) begin
				tree_text[$urandom_range(tree_text.size() - 1)] = 8'($urandom_range(255));
			end else if (pick < 35 && tree_text.size() > 1) begin
				cut = $urandom_range(tree_text.size() - 1, 1);
				while (tree_text.size() > cut) void'(tree_text.pop_back());
			end
		end
		send_text($urandom_range(1));
		repeat ($urandom_range(2))
			send_char(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_string("(a:0,b:1.5)", 1'b0);
		send_char(8'hFF, 1'b0, 1'b0);
		send_string("z", 1'b1);
		send_string("(:0;", 1'b0);
		send_string("(:0,:0;", 1'b0);
		send_string("(:a", 1'b0);
		send_string("(q;", 1'b0);
		send_char(8'h00, 1'b1, 1'b0);

		req_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);

		while (chars_sent < 300) random_sequence();

		steady = 1'b1;
		tree_text.delete();
		put_tree(10, 1'b1);
		send_text(1'b1);
		tree_text.delete();
		repeat (ntsc_pkg::MAX_DEPTH + 1) tree_text.push_back(ntsc_pkg::CH_LPAREN);
		send_text(1'b0);
		steady = 1'b0;

		req_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d requests and checked %0d results: %0d accepted, %0d in error.",
			chars_sent, sb.checked, sb.accepted_seen, sb.errors_seen);
		$display("Deepest nesting reached was %0d levels; %0d mismatches were found.",
			sb.deepest, sb.mismatches);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			if (!long_hold_done && sb.checked >= 60) begin
				long_hold_done = 1'b1;
				res_stall <= 1'b1;
				repeat (300) @(posedge clk);
			end
			res_stall <= !steady && ($urandom_range(99) < 24);
			@(posedge clk);
			if (res_valid && !res_stall)
				sb.check_result(status, error_kind, expected_char, position, depth);
		end
	end

	initial begin
		#10ms;
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/ntsc_pkg.sv
rtl/ntsc_ram.sv
rtl/newick_tree_syntax_checker_core.sv
rtl/ntsc_checker.sv
dv/newick_tree_syntax_checker_core_tb.sv
